// File: src/gjust_pkg.sv
`timescale 1ns / 1ps

package gjust_pkg;

    // field and counter widths
    localparam int CHAR_W        = 8;
    localparam int CNT_W         = 6;
    localparam int MAX_WIDTH_DEF = 32;

    // line width after reset
    localparam logic [CNT_W-1:0] LINE_WIDTH_RST = CNT_W'(16);

    // padding character
    localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(32);

    // word queue depth and store banks (enough for queue entries plus the one being filled)
    localparam int WQ_DEPTH = 2;
    localparam int BANK_W   = 2;
    localparam int WBANKS   = 1 << BANK_W;

    // finished word handed from front to back
    typedef struct packed {
        logic              tl;
        logic [CNT_W-1:0]  len;
        logic [BANK_W-1:0] bank;
    } word_cmd_t;

    // read request into the word store
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [CNT_W-1:0]  idx;
    } word_rd_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num;
        logic [CNT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quo;
        logic [CNT_W-1:0] rem;
    } div_rsp_t;

    // one letter of the pending line and its end-of-word mark
    typedef struct packed {
        logic              endw;
        logic [CHAR_W-1:0] ch;
    } line_ent_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EMIT,
        ST_COPY
    } bk_state_t;

endpackage

// File: src/greedy_full_text_justify.sv
`timescale 1ns / 1ps

// Greedy full-justification of a character stream. Words arrive one letter per
// transaction (tlast ends a word, tuser ends the text) and leave as lines of exactly
// line_width characters, the last one marked with tlast. The front end takes one
// letter per cycle into a four-bank word store and hands finished words to the back
// end through a two-entry queue; it holds off input only while that queue is full.
// The back end takes one word at a time: a decision state, then a copy state that
// writes the word into the line store one letter at a time. Each emitted line passes
// through a setup state, the gap divider when the line is fully justified, and
// line_width characters of output, one character per cycle while m_tready allows.
// There is no clearing pass after reset. A line_width of 0 acts as 1 and values
// above MAX_WIDTH act as MAX_WIDTH; write it only while the block is idle.

module greedy_full_text_justify #(
    parameter int MAX_WIDTH = gjust_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: line_width
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gjust_pkg::CNT_W-1:0]   cfg_data,
    // input letters
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gjust_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                          s_tlast,   // word_last
    input  logic                          s_tuser,   // [0] text_last
    // output characters
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gjust_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] out_char
    output logic                          m_tlast    // line_end
);

    logic [gjust_pkg::CNT_W-1:0] line_width_reg, line_width_next;
    logic [gjust_pkg::CNT_W-1:0] w;

    logic                        push;
    gjust_pkg::word_cmd_t        push_data;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    gjust_pkg::word_cmd_t        q_data;
    gjust_pkg::word_rd_t         word_rd;
    logic [gjust_pkg::CHAR_W-1:0] word_data;
    gjust_pkg::div_req_t         div_req;
    gjust_pkg::div_rsp_t         div_rsp;

    // configuration register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        line_width_next = line_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            line_width_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= gjust_pkg::LINE_WIDTH_RST;
        end
        else
        begin
            line_width_reg <= line_width_next;
        end
    end

    // effective width, clamped to 1..MAX_WIDTH
    always_comb
    begin
        if (line_width_reg == '0)
        begin
            w = gjust_pkg::CNT_W'(1);
        end
        else if (line_width_reg > gjust_pkg::CNT_W'(MAX_WIDTH))
        begin
            w = gjust_pkg::CNT_W'(MAX_WIDTH);
        end
        else
        begin
            w = line_width_reg;
        end
    end

    gjust_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .w         (w),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata),
        .word_last (s_tlast),
        .text_last (s_tuser),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full),
        .rd_req    (word_rd),
        .rd_data   (word_data)
    );

    gjust_fifo #(
        .DEPTH (gjust_pkg::WQ_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    gjust_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gjust_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .w         (w),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .word_rd   (word_rd),
        .word_data (word_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .line_end  (m_tlast)
    );

endmodule

// File: src/gjust_fifo.sv
`timescale 1ns / 1ps

module gjust_fifo #(
    parameter int DEPTH = gjust_pkg::WQ_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gjust_pkg::word_cmd_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output gjust_pkg::word_cmd_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gjust_pkg::word_cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/gjust_front.sv
`timescale 1ns / 1ps

module gjust_front #(
    parameter int MAX_WIDTH = gjust_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [gjust_pkg::CNT_W-1:0]       w,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gjust_pkg::CHAR_W-1:0]      char_code,
    input  logic                              word_last,
    input  logic                              text_last,
    output logic                              push,
    output gjust_pkg::word_cmd_t              push_data,
    input  logic                              q_full,
    input  gjust_pkg::word_rd_t               rd_req,
    output logic [gjust_pkg::CHAR_W-1:0]      rd_data
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH = gjust_pkg::WBANKS * (1 << AW);

    logic [gjust_pkg::CHAR_W-1:0] word_mem [DEPTH];
    logic [gjust_pkg::CHAR_W-1:0] rd_data_reg;

    logic [gjust_pkg::CNT_W-1:0]  word_len_reg, word_len_next;
    logic [gjust_pkg::BANK_W-1:0] bank_reg, bank_next;

    logic                         accept;
    logic                         word_done;
    logic                         store;
    logic [gjust_pkg::CNT_W-1:0]  len_inc;

    // a full queue holds off all characters
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign word_done = word_last || text_last;
    assign store     = (word_len_reg < w);
    assign len_inc   = store ? word_len_reg + 1'b1 : word_len_reg;

    // word length and bank bookkeeping, queue push on word end
    always_comb
    begin
        word_len_next  = word_len_reg;
        bank_next      = bank_reg;
        push           = 1'b0;
        push_data.tl   = text_last;
        push_data.len  = (len_inc > w) ? w : len_inc;
        push_data.bank = bank_reg;
        if (accept)
        begin
            word_len_next = len_inc;
            if (word_done)
            begin
                push          = 1'b1;
                word_len_next = '0;
                bank_next     = bank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg <= '0;
            bank_reg     <= '0;
        end
        else
        begin
            word_len_reg <= word_len_next;
            bank_reg     <= bank_next;
        end
    end

    // word store: letters beyond the width are dropped
    always_ff @(posedge clk)
    begin
        if (accept && store)
        begin
            word_mem[{bank_reg, word_len_reg[AW-1:0]}] <= char_code;
        end
        rd_data_reg <= word_mem[{rd_req.bank, rd_req.idx[AW-1:0]}];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/gjust_div.sv
`timescale 1ns / 1ps

module gjust_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gjust_pkg::div_req_t req,
    output gjust_pkg::div_rsp_t rsp
);

    localparam int W      = gjust_pkg::CNT_W;
    localparam int STEP_W = $clog2(W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      den_reg, den_next;

    logic [W:0]        trial;
    logic              ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W-2:0], ge};
            rem_next = ge ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: src/gjust_back.sv
`timescale 1ns / 1ps

module gjust_back #(
    parameter int MAX_WIDTH = gjust_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gjust_pkg::CNT_W-1:0]   w,
    input  logic                          q_valid,
    input  gjust_pkg::word_cmd_t          q_data,
    output logic                          q_pop,
    output gjust_pkg::word_rd_t           word_rd,
    input  logic [gjust_pkg::CHAR_W-1:0]  word_data,
    output gjust_pkg::div_req_t           div_req,
    input  gjust_pkg::div_rsp_t           div_rsp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gjust_pkg::CHAR_W-1:0]  out_char,
    output logic                          line_end
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LDEPTH = 1 << AW;
    localparam int CW     = gjust_pkg::CNT_W;

    gjust_pkg::bk_state_t state_reg, state_next;

    // pending line
    gjust_pkg::line_ent_t line_mem [LDEPTH];
    gjust_pkg::line_ent_t line_rd_reg;
    logic                 line_we;
    logic [CW-1:0]        line_waddr;
    gjust_pkg::line_ent_t line_wdata;

    logic [CW-1:0] letters_reg, letters_next;
    logic [CW-1:0] words_reg, words_next;

    // current word
    logic [CW-1:0]                  len_reg, len_next;
    logic                           tl_reg, tl_next;
    logic [gjust_pkg::BANK_W-1:0]   bank_reg, bank_next;
    logic [CW-1:0]                  k_reg, k_next;

    // line emission
    logic          final_reg, final_next;
    logic          full_reg, full_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] extra_reg, extra_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] wd_reg, wd_next;
    logic [CW-1:0] spc_reg, spc_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [gjust_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                          out_end_reg, out_end_next;

    logic [CW-1:0] gaps;
    logic [CW+1:0] fit_sum;
    logic          need_break;
    logic          full_now;
    logic          advance;
    logic          last_pos;
    logic          copy_last;

    assign gaps       = (words_reg != '0) ? words_reg - 1'b1 : '0;
    assign fit_sum    = {2'b00, letters_reg} + {2'b00, words_reg} + {2'b00, q_data.len};
    assign need_break = (words_reg != '0) && (fit_sum > {2'b00, w});
    assign full_now   = !final_reg && (gaps != '0) &&
                        (({1'b0, letters_reg} + {1'b0, gaps}) <= {1'b0, w});
    assign advance    = !out_valid_reg || out_ready;
    assign last_pos   = (pos_reg == w - 1'b1);
    assign copy_last  = ((k_reg + 1'b1) == len_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gjust_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = need_break ? gjust_pkg::ST_PREP : gjust_pkg::ST_COPY;
                end
            end
            gjust_pkg::ST_PREP:
            begin
                state_next = full_now ? gjust_pkg::ST_DIV : gjust_pkg::ST_EMIT;
            end
            gjust_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = gjust_pkg::ST_EMIT;
                end
            end
            gjust_pkg::ST_EMIT:
            begin
                if (advance && last_pos)
                begin
                    state_next = final_reg ? gjust_pkg::ST_IDLE : gjust_pkg::ST_COPY;
                end
            end
            gjust_pkg::ST_COPY:
            begin
                if (copy_last)
                begin
                    state_next = tl_reg ? gjust_pkg::ST_PREP : gjust_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gjust_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        letters_next   = letters_reg;
        words_next     = words_reg;
        len_next       = len_reg;
        tl_next        = tl_reg;
        bank_next      = bank_reg;
        k_next         = k_reg;
        final_next     = final_reg;
        full_next      = full_reg;
        base_next      = base_reg;
        extra_next     = extra_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        wd_next        = wd_reg;
        spc_next       = spc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;
        q_pop          = 1'b0;
        line_we        = 1'b0;
        line_waddr     = letters_reg + k_reg;
        line_wdata.endw = copy_last;
        line_wdata.ch   = word_data;
        div_req.start  = 1'b0;
        div_req.num    = w - letters_reg;
        div_req.den    = gaps;

        case (state_reg)
            gjust_pkg::ST_IDLE:
            begin
                len_next   = q_data.len;
                tl_next    = q_data.tl;
                bank_next  = q_data.bank;
                k_next     = '0;
                final_next = 1'b0;
            end
            gjust_pkg::ST_PREP:
            begin
                pos_next  = '0;
                j_next    = '0;
                wd_next   = '0;
                spc_next  = '0;
                full_next = full_now;
                div_req.start = full_now;
            end
            gjust_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    base_next  = div_rsp.quo;
                    extra_next = div_rsp.rem;
                end
            end
            gjust_pkg::ST_EMIT:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_end_next   = last_pos;
                    pos_next       = pos_reg + 1'b1;
                    if (spc_reg != '0)
                    begin
                        // inside a gap
                        out_char_next = gjust_pkg::SPACE_CHAR;
                        spc_next      = spc_reg - 1'b1;
                    end
                    else if (j_reg < letters_reg)
                    begin
                        out_char_next = line_rd_reg.ch;
                        j_next        = j_reg + 1'b1;
                        if (line_rd_reg.endw && (wd_reg < gaps))
                        begin
                            wd_next  = wd_reg + 1'b1;
                            spc_next = full_reg ?
                                       base_reg + CW'(wd_reg < extra_reg) : CW'(1);
                        end
                    end
                    else
                    begin
                        // trailing pad
                        out_char_next = gjust_pkg::SPACE_CHAR;
                    end
                    if (last_pos)
                    begin
                        letters_next = '0;
                        words_next   = '0;
                        k_next       = '0;
                        q_pop        = final_reg;
                    end
                end
            end
            gjust_pkg::ST_COPY:
            begin
                line_we = 1'b1;
                k_next  = k_reg + 1'b1;
                if (copy_last)
                begin
                    letters_next = letters_reg + len_reg;
                    words_next   = words_reg + 1'b1;
                    final_next   = tl_reg;
                    q_pop        = !tl_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign word_rd.bank = bank_next;
    assign word_rd.idx  = k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gjust_pkg::ST_IDLE;
            letters_reg   <= '0;
            words_reg     <= '0;
            k_reg         <= '0;
            final_reg     <= 1'b0;
            pos_reg       <= '0;
            j_reg         <= '0;
            wd_reg        <= '0;
            spc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            letters_reg   <= letters_next;
            words_reg     <= words_next;
            k_reg         <= k_next;
            final_reg     <= final_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            wd_reg        <= wd_next;
            spc_reg       <= spc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        tl_reg       <= tl_next;
        bank_reg     <= bank_next;
        full_reg     <= full_next;
        base_reg     <= base_next;
        extra_reg    <= extra_next;
        out_char_reg <= out_char_next;
        out_end_reg  <= out_end_next;
    end

    // line store: write during copy, read one letter ahead of emission
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr[AW-1:0]] <= line_wdata;
        end
        line_rd_reg <= line_mem[j_next[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign line_end  = out_end_reg;

endmodule
